@@ rtl/core/fpa_pkg.sv @@
// fpa_pkg: types and constants shared by the fixed partition allocator
// no dependencies; used by every module under rtl/core
`default_nettype none

package fpa_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned PID_W    = 16;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST   = 3'd0,
        OP_BEST    = 3'd1,
        OP_WORST   = 3'd2,
        OP_NEXT    = 3'd3,
        OP_RELEASE = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_NOID  = 2'd2,
        ST_BADOP = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // verdict of the shared compare unit for one candidate
    typedef struct packed {
        logic hit;   // candidate qualifies
        logic take;  // candidate replaces the current pick
    } cmp_res_t;

    // state update issued by the sequencer at the end of a search
    typedef struct packed {
        logic             alloc;
        logic             free;
        logic [IDX_W-1:0] idx;
        logic [PID_W-1:0] pid;
        logic             ptr_we;
        logic [IDX_W-1:0] ptr;
    } commit_t;

endpackage

`default_nettype wire

@@ rtl/core/fpa_size_regs.sv @@
// fpa_size_regs: partition size configuration registers with one read port
// depends on fpa_pkg
`default_nettype none

module fpa_size_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [fpa_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [fpa_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic [fpa_pkg::IDX_W-1:0]    rd_idx,
    output logic      [fpa_pkg::SIZE_W-1:0]   rd_size
);

    logic [fpa_pkg::SIZE_W-1:0] size_reg [fpa_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpa_pkg::NUM_REGS; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            size_reg[cfg_index] <= cfg_data;
        end
    end

    assign rd_size = size_reg[rd_idx];

endmodule

`default_nettype wire

@@ rtl/core/fpa_part_table.sv @@
// fpa_part_table: occupancy flags, owner ids and the next fit pointer
// depends on fpa_pkg (commit_t)
`default_nettype none

module fpa_part_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fpa_pkg::commit_t            commit,
    input  wire logic [fpa_pkg::IDX_W-1:0]   rd_idx,
    output logic                             rd_occ,
    output logic      [fpa_pkg::PID_W-1:0]   rd_owner,
    output logic      [fpa_pkg::IDX_W-1:0]   next_ptr
);

    logic                       occ_reg   [fpa_pkg::NUM_REGS];
    logic [fpa_pkg::PID_W-1:0]  owner_reg [fpa_pkg::NUM_REGS];
    logic [fpa_pkg::IDX_W-1:0]  ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpa_pkg::NUM_REGS; i++)
            begin
                occ_reg[i]   <= 1'b0;
                owner_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end
        else
        begin
            if (commit.alloc)
            begin
                occ_reg[commit.idx]   <= 1'b1;
                owner_reg[commit.idx] <= commit.pid;
            end
            else if (commit.free)
            begin
                occ_reg[commit.idx]   <= 1'b0;
                owner_reg[commit.idx] <= '0;
            end
            if (commit.ptr_we)
            begin
                ptr_reg <= commit.ptr;
            end
        end
    end

    assign rd_occ   = occ_reg[rd_idx];
    assign rd_owner = owner_reg[rd_idx];
    assign next_ptr = ptr_reg;

endmodule

`default_nettype wire

@@ rtl/core/fpa_cmp_unit.sv @@
// fpa_cmp_unit: shared compare unit, judges one partition per cycle
// depends on fpa_pkg (op codes, cmp_res_t)
`default_nettype none

module fpa_cmp_unit (
    input  wire logic [fpa_pkg::OP_W-1:0]    op,
    input  wire logic [fpa_pkg::SIZE_W-1:0]  req,
    input  wire logic [fpa_pkg::PID_W-1:0]   pid,
    input  wire logic [fpa_pkg::SIZE_W-1:0]  cand_size,
    input  wire logic                        cand_occ,
    input  wire logic [fpa_pkg::PID_W-1:0]   cand_owner,
    input  wire logic                        pick_valid,
    input  wire logic [fpa_pkg::SIZE_W-1:0]  pick_size,
    output fpa_pkg::cmp_res_t                res
);

    logic fits;
    logic owned;
    logic better;

    always_comb
    begin
        fits   = !cand_occ && (cand_size != '0) && (cand_size >= req);
        owned  = cand_occ && (cand_owner == pid);
        better = 1'b0;
        if (op == fpa_pkg::OP_BEST)
        begin
            better = cand_size < pick_size;
        end
        else if (op == fpa_pkg::OP_WORST)
        begin
            better = cand_size > pick_size;
        end
        res.hit  = (op == fpa_pkg::OP_RELEASE) ? owned : fits;
        res.take = res.hit && (!pick_valid || better);
    end

endmodule

`default_nettype wire

@@ rtl/core/fixed_partition_allocator.sv @@
// fixed_partition_allocator: top level, request sequencer and result registers
// depends on fpa_pkg, fpa_size_regs, fpa_part_table, fpa_cmp_unit
//
//  channel   handshake          payload
//  request   start / busy       opcode, request_size, process_id
//  result    done (strobe)      status, part_index, part_size
//  config    cfg_we             cfg_index, cfg_data
//
// a request is taken when start is high and busy is low
// allocations and releases walk the partitions one per cycle through a single
// compare unit, cut short on the first hit for first fit, next fit and release;
// best and worst fit always scan every partition
// the result strobe comes in the cycle after the last scan cycle, and busy is
// already low then; an invalid opcode answers on the cycle after acceptance
// the receiver cannot stall; reset clears sizes, occupancy, owners and pointer
`default_nettype none

module fixed_partition_allocator #(
    parameter int NUM_PARTS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request transaction
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [fpa_pkg::OP_W-1:0]     opcode,
    input  wire logic [fpa_pkg::SIZE_W-1:0]   request_size,
    input  wire logic [fpa_pkg::PID_W-1:0]    process_id,
    // result transaction
    output logic                              done,
    output logic      [fpa_pkg::STAT_W-1:0]   status,
    output logic      [fpa_pkg::IDX_W-1:0]    part_index,
    output logic      [fpa_pkg::SIZE_W-1:0]   part_size,
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [fpa_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [fpa_pkg::SIZE_W-1:0]   cfg_data
);

    localparam int unsigned IW = fpa_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PARTS - 1);

    // sequencer state
    fpa_pkg::state_t                state_reg, state_next;
    logic [fpa_pkg::OP_W-1:0]       op_reg, op_next;
    logic [fpa_pkg::SIZE_W-1:0]     req_reg, req_next;
    logic [fpa_pkg::PID_W-1:0]      pid_reg, pid_next;
    logic [IW-1:0]                  idx_reg, idx_next;   // partition under test
    logic [IW-1:0]                  cnt_reg, cnt_next;   // scan step
    logic                           pick_valid_reg, pick_valid_next;
    logic [IW-1:0]                  pick_idx_reg, pick_idx_next;
    logic [fpa_pkg::SIZE_W-1:0]     pick_size_reg, pick_size_next;

    // result registers
    logic                           done_reg, done_next;
    fpa_pkg::status_t               status_reg, status_next;
    logic [IW-1:0]                  part_index_reg, part_index_next;
    logic [fpa_pkg::SIZE_W-1:0]     part_size_reg, part_size_next;

    logic                           accept;
    logic                           op_valid;
    logic                           stop_first;
    logic                           last_step;
    logic                           found;
    logic [IW-1:0]                  final_idx;
    logic [fpa_pkg::SIZE_W-1:0]     final_size;

    logic [fpa_pkg::SIZE_W-1:0]     cand_size;
    logic                           cand_occ;
    logic [fpa_pkg::PID_W-1:0]      cand_owner;
    logic [IW-1:0]                  next_ptr;
    fpa_pkg::cmp_res_t              cmp;
    fpa_pkg::commit_t               commit;

    fpa_size_regs u_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_idx    (idx_reg),
        .rd_size   (cand_size)
    );

    fpa_part_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .rd_idx   (idx_reg),
        .rd_occ   (cand_occ),
        .rd_owner (cand_owner),
        .next_ptr (next_ptr)
    );

    fpa_cmp_unit u_cmp (
        .op         (op_reg),
        .req        (req_reg),
        .pid        (pid_reg),
        .cand_size  (cand_size),
        .cand_occ   (cand_occ),
        .cand_owner (cand_owner),
        .pick_valid (pick_valid_reg),
        .pick_size  (pick_size_reg),
        .res        (cmp)
    );

    assign accept   = start && (state_reg == fpa_pkg::S_IDLE);
    assign op_valid = (opcode == fpa_pkg::OP_FIRST) || (opcode == fpa_pkg::OP_BEST)
                   || (opcode == fpa_pkg::OP_WORST) || (opcode == fpa_pkg::OP_NEXT)
                   || (opcode == fpa_pkg::OP_RELEASE);

    // best and worst fit must see every partition, the rest stop on a hit
    assign stop_first = (op_reg != fpa_pkg::OP_BEST) && (op_reg != fpa_pkg::OP_WORST);
    assign last_step  = (cnt_reg == LAST_IDX) || (cmp.take && stop_first);
    assign found      = cmp.take || pick_valid_reg;
    assign final_idx  = cmp.take ? idx_reg : pick_idx_reg;
    assign final_size = cmp.take ? cand_size : pick_size_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpa_pkg::S_IDLE:
            begin
                if (accept && op_valid)
                begin
                    state_next = fpa_pkg::S_SCAN;
                end
            end
            fpa_pkg::S_SCAN:
            begin
                if (last_step)
                begin
                    state_next = fpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, commit and result values
    always_comb
    begin
        op_next         = op_reg;
        req_next        = req_reg;
        pid_next        = pid_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pick_valid_next = pick_valid_reg;
        pick_idx_next   = pick_idx_reg;
        pick_size_next  = pick_size_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        part_index_next = part_index_reg;
        part_size_next  = part_size_reg;
        commit          = '0;

        unique case (state_reg)
            fpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    req_next        = request_size;
                    pid_next        = process_id;
                    cnt_next        = '0;
                    pick_valid_next = 1'b0;
                    // next fit starts at the circular pointer
                    idx_next = (opcode == fpa_pkg::OP_NEXT) ? next_ptr : '0;
                    if (!op_valid)
                    begin
                        done_next       = 1'b1;
                        status_next     = fpa_pkg::ST_BADOP;
                        part_index_next = '0;
                        part_size_next  = '0;
                    end
                end
            end
            fpa_pkg::S_SCAN:
            begin
                if (cmp.take)
                begin
                    pick_valid_next = 1'b1;
                    pick_idx_next   = idx_reg;
                    pick_size_next  = cand_size;
                end
                cnt_next = cnt_reg + 1'b1;
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                if (last_step)
                begin
                    done_next = 1'b1;
                    if (found)
                    begin
                        status_next     = fpa_pkg::ST_OK;
                        part_index_next = final_idx;
                        part_size_next  = final_size;
                        commit.idx      = final_idx;
                        commit.pid      = pid_reg;
                        commit.alloc    = (op_reg != fpa_pkg::OP_RELEASE);
                        commit.free     = (op_reg == fpa_pkg::OP_RELEASE);
                        commit.ptr_we   = (op_reg == fpa_pkg::OP_NEXT);
                        commit.ptr      = (final_idx == LAST_IDX) ? '0 : final_idx + 1'b1;
                    end
                    else
                    begin
                        status_next     = (op_reg == fpa_pkg::OP_RELEASE) ?
                                          fpa_pkg::ST_NOID : fpa_pkg::ST_NOFIT;
                        part_index_next = '0;
                        part_size_next  = '0;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fpa_pkg::S_IDLE;
            done_reg       <= 1'b0;
            pick_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            status_reg     <= fpa_pkg::ST_OK;
            part_index_reg <= '0;
            part_size_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            pick_valid_reg <= pick_valid_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            status_reg     <= status_next;
            part_index_reg <= part_index_next;
            part_size_reg  <= part_size_next;
        end
    end

    // request payload and running pick, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        req_reg       <= req_next;
        pid_reg       <= pid_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
    end

    assign busy       = (state_reg != fpa_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign part_index = part_index_reg;
    assign part_size  = part_size_reg;

endmodule

`default_nettype wire

@@ rtl/core/fpa_checker.sv @@
// fpa_checker: port-level assertions for the fixed partition allocator
// depends on fpa_pkg; bound to fixed_partition_allocator below
`default_nettype none

module fpa_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [fpa_pkg::OP_W-1:0]     opcode,
    input  wire logic                         done,
    input  wire logic [fpa_pkg::STAT_W-1:0]   status,
    input  wire logic [fpa_pkg::IDX_W-1:0]    part_index,
    input  wire logic [fpa_pkg::SIZE_W-1:0]   part_size
);

    // results only appear once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // the end of a search always produces a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without a result");

    // failed transactions report partition zero of size zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != fpa_pkg::ST_OK)) |-> ((part_index == '0) && (part_size == '0)))
        else $error("failed transaction carries a partition");

    // unknown opcodes are answered right away
    a_badop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode > fpa_pkg::OP_RELEASE))
        |=> (done && !busy && (status == fpa_pkg::ST_BADOP)))
        else $error("invalid opcode not rejected");

endmodule

bind fixed_partition_allocator fpa_checker u_fpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .done       (done),
    .status     (status),
    .part_index (part_index),
    .part_size  (part_size)
);

`default_nettype wire
